// File: rtl/core/sha256_message_hash_unit_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 message hash unit: assertion macros
// Shared assertion forms used by the hash unit.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASH_UNIT_MACROS_SVH
`define SHA256_MESSAGE_HASH_UNIT_MACROS_SVH

// Same-cycle implication under reset.
`define SHAMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define SHAMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/shamh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message hash package
// Types, payload structs, initial hash words and round constants.
// ----------------------------------------------------------------------------
package shamh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] vars_t;
    typedef word_t [15:0] window_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       end_of_message;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_beat_t;

    localparam vars_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/shamh_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
module shamh_round (
    input  shamh_pkg::vars_t   vars,
    input  shamh_pkg::window_t window,
    input  logic [5:0]         round_idx,
    output shamh_pkg::vars_t   vars_out,
    output shamh_pkg::word_t   sched_word
);
    import shamh_pkg::*;

    word_t s0;
    word_t s1;
    word_t big0;
    word_t big1;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        s0 = rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3);
        s1 = rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10);
        sched_word = window[0] + s0 + window[9] + s1;

        big1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
        ch   = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        t1   = vars[7] + big1 + ch + round_k(round_idx) + window[0];
        big0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
        maj  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t2   = big0 + maj;

        vars_out[7] = vars[6];
        vars_out[6] = vars[5];
        vars_out[5] = vars[4];
        vars_out[4] = vars[3] + t1;
        vars_out[3] = vars[2];
        vars_out[2] = vars[1];
        vars_out[1] = vars[0];
        vars_out[0] = t1 + t2;
    end

endmodule

// File: rtl/core/sha256_message_hash_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 message hash unit
// Hashes a byte stream with one shared round unit and emits the eight digest
// words after padding.
// ----------------------------------------------------------------------------
// A byte beat is taken only while idle; every 64th byte adds a compression
// (64 rounds through the single round unit, then the chaining add).
// An end beat adds padding, one or two compressions, then eight digest beats.
// Reset loads the initial hash words, clears the length and the byte position.
module sha256_message_hash_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  shamh_pkg::msg_beat_t msg,
    output logic                 dig_valid,
    input  logic                 dig_stall,
    output shamh_pkg::dig_beat_t dig
);
    import shamh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    vars_t       chain_reg, chain_next;
    vars_t       vars_reg, vars_next;
    window_t     win_reg, win_next;
    logic [23:0] acc_reg, acc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] count_reg, count_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;
    logic        sent_reg, sent_next;
    logic        tail_reg, tail_next;
    logic        pend_reg, pend_next;
    logic        done_reg, done_next;

    logic        push_en;
    logic [7:0]  push_byte;
    vars_t       round_vars;
    word_t       sched_word;

    shamh_round u_round (
        .vars       (vars_reg),
        .window     (win_reg),
        .round_idx  (rnd_reg),
        .vars_out   (round_vars),
        .sched_word (sched_word)
    );

    assign msg_stall       = (state_reg != S_IDLE);
    assign dig_valid       = (state_reg == S_OUT);
    assign dig.digest_word = chain_reg[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        vars_next  = vars_reg;
        win_next   = win_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        rnd_next   = rnd_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sent_next  = sent_reg;
        tail_next  = tail_reg;
        pend_next  = pend_reg;
        done_next  = done_reg;
        push_en    = 1'b0;
        push_byte  = 8'h00;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    push_en   = msg.has_byte;
                    push_byte = msg.byte_value;
                    if (msg.has_byte)
                    begin
                        count_next = count_reg + 64'd8;
                    end
                    if (msg.end_of_message)
                    begin
                        pend_next  = 1'b1;
                        sent_next  = 1'b0;
                        tail_next  = 1'b0;
                        len_next   = 3'd0;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                push_en = 1'b1;
                if (!sent_reg)
                begin
                    push_byte = PAD_MARK;
                    sent_next = 1'b1;
                    tail_next = (pos_reg < 6'd56);
                end
                else if (tail_reg && pos_reg >= 6'd56)
                begin
                    push_byte = count_reg[6'd63 - {len_reg, 3'd0} -: 8];
                    len_next  = len_reg + 3'd1;
                    if (len_reg == 3'd7)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_RND:
            begin
                vars_next = round_vars;
                win_next  = {sched_word, win_reg[15:1]};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                priority if (done_reg)
                begin
                    state_next = S_OUT;
                end
                else if (pend_reg)
                begin
                    tail_next  = 1'b1;
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!dig_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        chain_next = H_INIT;
                        count_next = 64'd0;
                        done_next  = 1'b0;
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            acc_next = {acc_reg[15:0], push_byte};
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'd3)
            begin
                win_next = {{acc_reg, push_byte}, win_reg[15:1]};
            end
            if (pos_reg == 6'd63)
            begin
                vars_next  = chain_reg;
                rnd_next   = 6'd0;
                state_next = S_RND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chain_reg <= H_INIT;
            pos_reg   <= 6'd0;
            count_reg <= 64'd0;
            rnd_reg   <= 6'd0;
            len_reg   <= 3'd0;
            idx_reg   <= 3'd0;
            sent_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            rnd_reg   <= rnd_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sent_reg  <= sent_next;
            tail_reg  <= tail_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        win_reg  <= win_next;
        acc_reg  <= acc_next;
    end

`include "sha256_message_hash_unit_macros.svh"

    `SHAMH_ASSERT_NOW(a_rnd_idle, (state_reg == S_IDLE || state_reg == S_OUT), (rnd_reg == 6'd0), "round counter not at rest")
    `SHAMH_ASSERT_NOW(a_out_aligned, (state_reg == S_OUT), (pos_reg == 6'd0 && done_reg), "digest output with partial block")
    `SHAMH_ASSERT_NEXT(a_last_restart, (dig_valid && !dig_stall && dig.last_word), (state_reg == S_IDLE && count_reg == 64'd0), "no restart after last word")

endmodule
